/* sv/assert_macros.svh */
// Assertion macros used by the RTL of the loader.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock edge, ignored while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Implication form of the same check.
`define ASSERT_IMPL(label, ante, cons, msg) \
    `ASSERT_CLK(label, (ante) |-> (cons), msg)

`endif

/* sv/ihexl_pkg.sv */
// Types, constants and the helper function of the Intel HEX record loader.
package ihexl_pkg;

    // Address wrap width; the emitted address is always 16 bits.
    localparam int ADDR_BITS = 16;
    localparam logic [15:0] ADDR_MASK = 16'(((33'd1 << ADDR_BITS) - 33'd1) & 33'hFFFF);

    // Output beat layout.
    localparam int OUT_DATA_BITS = 40;

    // Characters recognized by the parser.
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_LO_R  = 8'h72;
    localparam logic [7:0] CH_UP_R  = 8'h52;
    localparam logic [7:0] CH_UP_X  = 8'h58;
    localparam logic [7:0] CASE_FOLD_MASK = 8'hDF;

    // Record types.
    localparam logic [7:0] REC_DATA = 8'h00;
    localparam logic [7:0] REC_EOF  = 8'h01;
    localparam logic [7:0] REC_PAGE = 8'h04;

    typedef enum logic [3:0] {
        PH_IDLE  = 4'd0,
        PH_XCOPY = 4'd1,
        PH_SKIP  = 4'd2,
        PH_LEN   = 4'd3,
        PH_AHI   = 4'd4,
        PH_ALO   = 4'd5,
        PH_TYPE  = 4'd6,
        PH_DATA  = 4'd7,
        PH_CSUM  = 4'd8,
        PH_PAGE0 = 4'd9,
        PH_PAGE1 = 4'd10
    } t_phase;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_SUM_MISMATCH = 3'd1,
        ST_EOF         = 3'd2,
        ST_PAGE_SET    = 3'd3,
        ST_UNSUPPORTED = 3'd4,
        ST_BAD_DIGIT   = 3'd5,
        ST_BAD_PAGE    = 3'd6,
        ST_NOT_ATTACHED = 3'd7
    } t_status;

    typedef struct packed {
        logic        is_write;
        logic        write_page;
        logic [15:0] write_addr;
        logic [7:0]  write_data;
        t_status     status;
        logic [7:0]  sum_residue;
    } t_result;

    // Hex digit value; bit 4 set marks a character that is not a hex digit.
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        v = 5'h10;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = 5'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = 5'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = 5'(c - 8'h37);
        end
        return v;
    endfunction

endpackage

/* sv/intel_hex_record_loader.sv */
// Intel HEX record loader: character stream in, memory writes and record status out.
//
// The loader takes one received character per input beat and answers with at
// most one output beat: either a memory write (tuser bit 0 high) carrying the
// extended page bit, a 16-bit address and the data byte, or a record status
// (tuser bit 0 low) with a 3-bit code and, on a checksum mismatch, the
// nonzero byte sum. Outside a record, ':' opens a record, 'a'/'A' attaches,
// 'r'/'R' releases (both clear the extended page) and 'x'/'X' toggles a
// pass-through in which every character is ignored. Records are read as hex
// pairs of length, address and type; type 00 writes each data byte and then
// checks the sum without a skip, type 04 sets the page, and every other error
// or type reports a status and skips to the next CR or LF. The parser state
// and the result register both update at the accepting edge, so a new
// character is accepted every cycle as long as the output register is empty
// or being drained in the same cycle. The only combinational path from output
// to input is tready, through the output register's occupancy.
`include "assert_macros.svh"

module intel_hex_record_loader (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_char
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] write_page, [16:1] write_addr, [24:17] write_data, [27:25] status,
    // [35:28] sum_residue, [39:36] zero
    output logic [ihexl_pkg::OUT_DATA_BITS-1:0] m_axis_tdata,
    output logic [0:0]  m_axis_tuser    // [0] is_write
);

    // Parser state.
    ihexl_pkg::t_phase r_phase, n_phase;
    logic        r_hi_seen, n_hi_seen;
    logic [3:0]  r_hi_nib, n_hi_nib;
    logic [7:0]  r_rec_len, n_rec_len;
    logic [7:0]  r_bytes_left, n_bytes_left;
    logic [15:0] r_addr, n_addr;
    logic [7:0]  r_sum, n_sum;
    logic        r_page, n_page;
    logic        r_attached, n_attached;

    // Result of the current character and the output register.
    logic                r_out_valid;
    ihexl_pkg::t_result  r_out;
    ihexl_pkg::t_result  n_res;
    logic                n_res_valid;

    logic       w_in_beat;
    logic [4:0] w_digit;
    logic [7:0] w_byte;
    logic [7:0] w_sum_add;
    logic [7:0] w_char;

    // The output register accepts a new result whenever it is empty or drains now.
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_in_beat     = s_axis_tvalid && s_axis_tready;
    assign w_char        = s_axis_tdata;
    assign w_digit       = ihexl_pkg::hex_value(w_char);
    assign w_byte        = {r_hi_nib, w_digit[3:0]};
    assign w_sum_add     = r_sum + w_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= ihexl_pkg::PH_IDLE;
            r_hi_seen    <= 1'b0;
            r_hi_nib     <= '0;
            r_rec_len    <= '0;
            r_bytes_left <= '0;
            r_addr       <= '0;
            r_sum        <= '0;
            r_page       <= 1'b0;
            r_attached   <= 1'b1;
        end else if (w_in_beat) begin
            r_phase      <= n_phase;
            r_hi_seen    <= n_hi_seen;
            r_hi_nib     <= n_hi_nib;
            r_rec_len    <= n_rec_len;
            r_bytes_left <= n_bytes_left;
            r_addr       <= n_addr;
            r_sum        <= n_sum;
            r_page       <= n_page;
            r_attached   <= n_attached;
        end
    end

    // Next state and result for the character on the input.
    always_comb begin
        n_phase      = r_phase;
        n_hi_seen    = r_hi_seen;
        n_hi_nib     = r_hi_nib;
        n_rec_len    = r_rec_len;
        n_bytes_left = r_bytes_left;
        n_addr       = r_addr;
        n_sum        = r_sum;
        n_page       = r_page;
        n_attached   = r_attached;
        n_res_valid  = 1'b0;
        n_res        = '0;

        case (r_phase)
            ihexl_pkg::PH_IDLE: begin
                if (w_char == ihexl_pkg::CH_COLON) begin
                    if (!r_attached) begin
                        n_res_valid = 1'b1;
                        n_res.status = ihexl_pkg::ST_NOT_ATTACHED;
                        n_phase = ihexl_pkg::PH_SKIP;
                        n_hi_seen = 1'b0;
                    end else begin
                        n_sum = '0;
                        n_hi_seen = 1'b0;
                        n_phase = ihexl_pkg::PH_LEN;
                    end
                end else if (w_char == ihexl_pkg::CH_LO_A || w_char == ihexl_pkg::CH_UP_A) begin
                    n_attached = 1'b1;
                    n_page = 1'b0;
                end else if (w_char == ihexl_pkg::CH_LO_R || w_char == ihexl_pkg::CH_UP_R) begin
                    n_attached = 1'b0;
                    n_page = 1'b0;
                end else if ((w_char & ihexl_pkg::CASE_FOLD_MASK) == ihexl_pkg::CH_UP_X) begin
                    n_phase = ihexl_pkg::PH_XCOPY;
                end
            end
            ihexl_pkg::PH_XCOPY: begin
                if ((w_char & ihexl_pkg::CASE_FOLD_MASK) == ihexl_pkg::CH_UP_X) begin
                    n_phase = ihexl_pkg::PH_IDLE;
                end
            end
            ihexl_pkg::PH_SKIP: begin
                if (w_char == ihexl_pkg::CH_LF || w_char == ihexl_pkg::CH_CR) begin
                    n_phase = ihexl_pkg::PH_IDLE;
                end
            end
            ihexl_pkg::PH_LEN, ihexl_pkg::PH_AHI, ihexl_pkg::PH_ALO,
            ihexl_pkg::PH_TYPE, ihexl_pkg::PH_DATA, ihexl_pkg::PH_CSUM,
            ihexl_pkg::PH_PAGE0, ihexl_pkg::PH_PAGE1: begin
                if (w_digit[4]) begin
                    // Not a hex digit: report and drop the rest of the line.
                    n_res_valid = 1'b1;
                    n_res.status = (r_phase == ihexl_pkg::PH_PAGE0 ||
                                    r_phase == ihexl_pkg::PH_PAGE1)
                                   ? ihexl_pkg::ST_BAD_PAGE : ihexl_pkg::ST_BAD_DIGIT;
                    n_phase = ihexl_pkg::PH_SKIP;
                    n_hi_seen = 1'b0;
                end else if (!r_hi_seen) begin
                    n_hi_nib = w_digit[3:0];
                    n_hi_seen = 1'b1;
                end else begin
                    n_hi_seen = 1'b0;
                    case (r_phase)
                        ihexl_pkg::PH_LEN: begin
                            n_rec_len = w_byte;
                            n_bytes_left = w_byte;
                            n_sum = w_byte;
                            n_phase = ihexl_pkg::PH_AHI;
                        end
                        ihexl_pkg::PH_AHI: begin
                            n_addr = {w_byte, 8'h00};
                            n_sum = w_sum_add;
                            n_phase = ihexl_pkg::PH_ALO;
                        end
                        ihexl_pkg::PH_ALO: begin
                            n_addr = (r_addr | {8'h00, w_byte}) & ihexl_pkg::ADDR_MASK;
                            n_sum = w_sum_add;
                            n_phase = ihexl_pkg::PH_TYPE;
                        end
                        ihexl_pkg::PH_TYPE: begin
                            n_sum = w_sum_add;
                            if (w_byte == ihexl_pkg::REC_DATA) begin
                                n_phase = (r_rec_len != '0) ? ihexl_pkg::PH_DATA
                                                            : ihexl_pkg::PH_CSUM;
                            end else if (w_byte == ihexl_pkg::REC_EOF) begin
                                n_res_valid = 1'b1;
                                n_res.status = ihexl_pkg::ST_EOF;
                                n_phase = ihexl_pkg::PH_SKIP;
                            end else if (w_byte == ihexl_pkg::REC_PAGE) begin
                                n_phase = ihexl_pkg::PH_PAGE0;
                            end else begin
                                n_res_valid = 1'b1;
                                n_res.status = ihexl_pkg::ST_UNSUPPORTED;
                                n_phase = ihexl_pkg::PH_SKIP;
                            end
                        end
                        ihexl_pkg::PH_DATA: begin
                            n_sum = w_sum_add;
                            n_res_valid = 1'b1;
                            n_res.is_write = 1'b1;
                            n_res.write_page = r_page;
                            n_res.write_addr = r_addr;
                            n_res.write_data = w_byte;
                            n_addr = (r_addr + 16'd1) & ihexl_pkg::ADDR_MASK;
                            n_bytes_left = r_bytes_left - 8'd1;
                            if (r_bytes_left == 8'd1) begin
                                n_phase = ihexl_pkg::PH_CSUM;
                            end
                        end
                        ihexl_pkg::PH_CSUM: begin
                            n_sum = w_sum_add;
                            n_phase = ihexl_pkg::PH_IDLE;
                            n_res_valid = 1'b1;
                            n_res.status = (w_sum_add != '0) ? ihexl_pkg::ST_SUM_MISMATCH
                                                             : ihexl_pkg::ST_OK;
                            n_res.sum_residue = w_sum_add;
                        end
                        ihexl_pkg::PH_PAGE0: begin
                            if (w_byte != 8'h00) begin
                                n_res_valid = 1'b1;
                                n_res.status = ihexl_pkg::ST_BAD_PAGE;
                                n_phase = ihexl_pkg::PH_SKIP;
                            end else begin
                                n_phase = ihexl_pkg::PH_PAGE1;
                            end
                        end
                        default: begin
                            // Second page byte: only 0 or 1 is a valid page.
                            n_res_valid = 1'b1;
                            n_phase = ihexl_pkg::PH_SKIP;
                            if (w_byte[7:1] != 7'd0) begin
                                n_res.status = ihexl_pkg::ST_BAD_PAGE;
                            end else begin
                                n_page = w_byte[0];
                                n_res.status = ihexl_pkg::ST_PAGE_SET;
                            end
                        end
                    endcase
                end
            end
            default: begin
                n_phase = ihexl_pkg::PH_IDLE;
            end
        endcase
    end

    // Output register: loads on every input beat, empties when the sink takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_in_beat) begin
            r_out_valid <= n_res_valid;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_beat && n_res_valid) begin
            r_out <= n_res;
        end
    end

    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tuser[0] = r_out.is_write;
    assign m_axis_tdata    = {4'h0, r_out.sum_residue, r_out.status, r_out.write_data,
                              r_out.write_addr, r_out.write_page};

    // A write beat never carries a status code or a residue.
    `ASSERT_IMPL(a_write_clean, r_out_valid && r_out.is_write,
                 r_out.status == ihexl_pkg::ST_OK && r_out.sum_residue == 8'h00,
                 "write beat carries status or residue")

    // Only the data phase of a record produces a write.
    `ASSERT_IMPL(a_write_from_data, w_in_beat && r_phase != ihexl_pkg::PH_DATA,
                 ##1 !(r_out_valid && r_out.is_write),
                 "write produced outside the data phase")

    // Entering the line skip always comes with a reported status.
    `ASSERT_IMPL(a_skip_reports,
                 r_phase == ihexl_pkg::PH_SKIP && $past(r_phase) != ihexl_pkg::PH_SKIP,
                 r_out_valid && !r_out.is_write,
                 "line skip entered without a status beat")

    // A pending high nibble only exists inside a record.
    `ASSERT_IMPL(a_nibble_in_record, r_hi_seen,
                 r_phase != ihexl_pkg::PH_IDLE && r_phase != ihexl_pkg::PH_XCOPY &&
                 r_phase != ihexl_pkg::PH_SKIP,
                 "high nibble pending outside a record")

endmodule
